// ----- hw/rtl/sosc_pkg.sv -----
// ----------------------------------------------------------------------------
// Script opcode scan counter package
// Shared types and constants for the script opcode scanner: scan phase
// codes, opcode values and count widths.
// ----------------------------------------------------------------------------
package sosc_pkg;

  // Counter and byte widths.
  localparam int unsigned CountW = 32;
  localparam int unsigned ByteW  = 8;

  typedef logic [CountW-1:0] count_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [1:0]        phase_t;

  // Scan phase codes. The reserved code behaves like the opcode phase.
  localparam phase_t PhOpcode  = 2'd0;
  localparam phase_t PhLength  = 2'd1;
  localparam phase_t PhPayload = 2'd2;
  localparam phase_t PhRsvd    = 2'd3;

  // Configuration register indexes.
  localparam logic CfgAccurate = 1'b0;
  localparam logic CfgTarget   = 1'b1;

  // Opcode values in the usual script numbering.
  localparam byte_t OpZero        = 8'h00;
  localparam byte_t OpPushData1   = 8'h4c;
  localparam byte_t OpPushData2   = 8'h4d;
  localparam byte_t OpPushData4   = 8'h4e;
  localparam byte_t OpSmallBase   = 8'h50;
  localparam byte_t OpOne         = 8'h51;
  localparam byte_t OpSixteen     = 8'h60;
  localparam byte_t OpCheckSig    = 8'hac;
  localparam byte_t OpCheckSigVfy = 8'had;
  localparam byte_t OpMultiSig    = 8'hae;
  localparam byte_t OpMultiSigVfy = 8'haf;
  localparam byte_t OpInvalid     = 8'hff;

  // Sigops charged to a multisig whose key count is not known.
  localparam logic [4:0] MultiSigDefault = 5'd20;

  // Length field sizes of the three long push forms.
  localparam logic [2:0] LenBytes1 = 3'd1;
  localparam logic [2:0] LenBytes2 = 3'd2;
  localparam logic [2:0] LenBytes4 = 3'd4;

endpackage

// ----- hw/rtl/script_opcode_scan_counter.sv -----
// ----------------------------------------------------------------------------
// Script opcode scan counter
// Tokenizes a script one byte per word, skips push payloads, and on the last
// byte reports the sigop count, target opcode count, push-only and truncated.
// ----------------------------------------------------------------------------
// A last byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register feeds a combinational
// phase update and saturating counter adds, with a result register behind.
// Only a last byte waits, and only while an earlier result is held by a
// stalled receiver.
// Reset (synchronous, rst_n low): scan state and totals cleared, previous
// opcode set to invalid, accurate_mode = 1, target_opcode = 0.
module script_opcode_scan_counter (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration write port.
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [7:0]               cfg_wdata,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_script_byte,
  input  logic                     in_last_byte,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [31:0]              out_sigop_count,
  output logic [31:0]              out_target_count,
  output logic                     out_push_only,
  output logic                     out_truncated
);

  // Configuration registers.
  logic               accurate_r;
  sosc_pkg::byte_t    target_r;

  // Input register.
  logic               s1_valid_r;
  sosc_pkg::byte_t    s1_byte_r;
  logic               s1_last_r;

  // Scan state.
  sosc_pkg::phase_t   phase_r, phase_nxt;
  logic [2:0]         len_left_r, len_left_nxt;
  logic [1:0]         len_shift_r, len_shift_nxt;
  sosc_pkg::count_t   payload_r, payload_nxt;
  sosc_pkg::byte_t    prev_op_r, prev_op_nxt;
  sosc_pkg::count_t   sigop_r, sigop_nxt;
  sosc_pkg::count_t   match_r, match_nxt;
  logic               all_push_r, all_push_nxt;

  // Result register.
  logic               out_valid_r;
  sosc_pkg::count_t   out_sigop_r;
  sosc_pkg::count_t   out_match_r;
  logic               out_push_only_r;
  logic               out_trunc_r;

  // Datapath helpers.
  logic               s1_go;
  logic               s1_fire;
  logic               in_accept;
  logic               match_check;
  sosc_pkg::byte_t    match_op;
  logic               sigop_add;
  logic [4:0]         sigop_inc;
  logic [32:0]        sigop_sum;
  logic [32:0]        match_sum;
  sosc_pkg::count_t   payload_or;
  sosc_pkg::count_t   payload_dec;
  logic               trunc;

  // The held word may move on unless it is a last byte and the result
  // register is full and stalled.
  assign s1_go     = !s1_last_r || !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && s1_go;
  assign in_stall  = s1_valid_r && !s1_go;
  assign in_accept = in_valid && !in_stall;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accurate_r <= 1'b1;
      target_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sosc_pkg::CfgAccurate: accurate_r <= cfg_wdata[0];
        sosc_pkg::CfgTarget:   target_r   <= cfg_wdata;
        default:               ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_script_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Length byte merged into the payload count, little-endian.
  always_comb begin
    payload_or = payload_r;
    case (len_shift_r)
      2'd0:    payload_or[7:0]   = payload_r[7:0]   | s1_byte_r;
      2'd1:    payload_or[15:8]  = payload_r[15:8]  | s1_byte_r;
      2'd2:    payload_or[23:16] = payload_r[23:16] | s1_byte_r;
      default: payload_or[31:24] = payload_r[31:24] | s1_byte_r;
    endcase
  end

  assign payload_dec = payload_r - sosc_pkg::CountW'(1);

  // Phase update for one script byte.
  always_comb begin
    phase_nxt     = phase_r;
    len_left_nxt  = len_left_r;
    len_shift_nxt = len_shift_r;
    payload_nxt   = payload_r;
    prev_op_nxt   = prev_op_r;
    all_push_nxt  = all_push_r;
    match_check   = 1'b0;
    match_op      = prev_op_r;
    sigop_add     = 1'b0;
    sigop_inc     = 5'd1;

    unique case (phase_r)
      sosc_pkg::PhLength: begin
        payload_nxt   = payload_or;
        len_shift_nxt = len_shift_r + 2'd1;
        len_left_nxt  = len_left_r - 3'd1;
        if (len_left_nxt == 3'd0) begin
          if (payload_or == '0) begin
            // A zero-length push is complete after its length field.
            match_check = 1'b1;
            phase_nxt   = sosc_pkg::PhOpcode;
          end else begin
            phase_nxt = sosc_pkg::PhPayload;
          end
        end
      end
      sosc_pkg::PhPayload: begin
        payload_nxt = payload_dec;
        if (payload_dec == '0) begin
          match_check = 1'b1;
          phase_nxt   = sosc_pkg::PhOpcode;
        end
      end
      sosc_pkg::PhOpcode, sosc_pkg::PhRsvd: begin
        prev_op_nxt = s1_byte_r;
        match_op    = s1_byte_r;
        phase_nxt   = sosc_pkg::PhOpcode;
        if (s1_byte_r < sosc_pkg::OpPushData1) begin
          if (s1_byte_r == sosc_pkg::OpZero) begin
            match_check = 1'b1;
          end else begin
            payload_nxt = {24'd0, s1_byte_r};
            phase_nxt   = sosc_pkg::PhPayload;
          end
        end else if (s1_byte_r <= sosc_pkg::OpPushData4) begin
          if (s1_byte_r == sosc_pkg::OpPushData1) begin
            len_left_nxt = sosc_pkg::LenBytes1;
          end else if (s1_byte_r == sosc_pkg::OpPushData2) begin
            len_left_nxt = sosc_pkg::LenBytes2;
          end else begin
            len_left_nxt = sosc_pkg::LenBytes4;
          end
          len_shift_nxt = 2'd0;
          payload_nxt   = '0;
          phase_nxt     = sosc_pkg::PhLength;
        end else begin
          match_check = 1'b1;
          if (s1_byte_r > sosc_pkg::OpSixteen) begin
            all_push_nxt = 1'b0;
          end
          if (s1_byte_r == sosc_pkg::OpCheckSig || s1_byte_r == sosc_pkg::OpCheckSigVfy) begin
            sigop_add = 1'b1;
          end else if (s1_byte_r == sosc_pkg::OpMultiSig ||
                       s1_byte_r == sosc_pkg::OpMultiSigVfy) begin
            sigop_add = 1'b1;
            if (accurate_r && prev_op_r >= sosc_pkg::OpOne &&
                prev_op_r <= sosc_pkg::OpSixteen) begin
              sigop_inc = 5'(prev_op_r - sosc_pkg::OpSmallBase);
            end else begin
              sigop_inc = sosc_pkg::MultiSigDefault;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Saturating totals.
  assign sigop_sum = {1'b0, sigop_r} + {28'd0, sigop_inc};
  assign match_sum = {1'b0, match_r} + 33'd1;

  always_comb begin
    sigop_nxt = sigop_r;
    if (sigop_add) begin
      sigop_nxt = sigop_sum[32] ? '1 : sigop_sum[31:0];
    end
    match_nxt = match_r;
    if (match_check && match_op == target_r) begin
      match_nxt = match_sum[32] ? '1 : match_sum[31:0];
    end
  end

  assign trunc = (phase_nxt == sosc_pkg::PhLength) || (phase_nxt == sosc_pkg::PhPayload);

  // Scan state: advances on each byte, clears after the last one.
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_fire && s1_last_r)) begin
      phase_r     <= sosc_pkg::PhOpcode;
      len_left_r  <= '0;
      len_shift_r <= '0;
      payload_r   <= '0;
      prev_op_r   <= sosc_pkg::OpInvalid;
      sigop_r     <= '0;
      match_r     <= '0;
      all_push_r  <= 1'b1;
    end else if (s1_fire) begin
      phase_r     <= phase_nxt;
      len_left_r  <= len_left_nxt;
      len_shift_r <= len_shift_nxt;
      payload_r   <= payload_nxt;
      prev_op_r   <= prev_op_nxt;
      sigop_r     <= sigop_nxt;
      match_r     <= match_nxt;
      all_push_r  <= all_push_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_sigop_r     <= sigop_nxt;
      out_match_r     <= match_nxt;
      out_push_only_r <= all_push_nxt && !trunc;
      out_trunc_r     <= trunc;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sigop_count  = out_sigop_r;
  assign out_target_count = out_match_r;
  assign out_push_only    = out_push_only_r;
  assign out_truncated    = out_trunc_r;

  // The reserved phase code is never entered.
  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != sosc_pkg::PhRsvd)
    else $error("scan phase holds the reserved code");

  // A length phase always has length bytes still to come.
  a_len_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == sosc_pkg::PhLength |-> len_left_r != 3'd0)
    else $error("length phase with no length bytes left");

  // Totals start over once a last byte has been processed.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> phase_r == sosc_pkg::PhOpcode && sigop_r == '0 &&
                             match_r == '0 && all_push_r)
    else $error("scan state not cleared after last byte");

  // A truncated script is never reported as push-only.
  a_trunc_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_trunc_r && out_push_only_r))
    else $error("result both truncated and push-only");

  // A last byte waiting on a full, stalled result register blocks input.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_last_r && out_valid_r && out_stall |-> in_stall && !s1_fire)
    else $error("last byte advanced over a stalled result");

endmodule
